@@ rtl/cct_pkg.sv @@
`default_nettype none

package cct_pkg;

    // Grid and cluster geometry.
    localparam int GRID_DIM     = 4;
    localparam int CLUSTER_DIM  = 3;
    localparam int NUM_CLUSTERS = CLUSTER_DIM * CLUSTER_DIM;

    // Field widths.
    localparam int LINK_W    = 64;
    localparam int BYTE_W    = 8;
    localparam int RATIO_W   = 8;
    localparam int THR_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    // Internal arithmetic widths: a 2x2 sum and the hadronic sum reach 1020,
    // a cluster total 2040, the ratio products 260100.
    localparam int ESUM_W  = 10;
    localparam int TOT_W   = 11;
    localparam int PROD_W  = 18;
    localparam int ETOT_W  = 12;
    localparam int JSUM_W  = 13;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_EM_RATIO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HAD_RATIO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EM_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EM_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HAD_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HAD_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_JET_ECAL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_JET_TOTAL = 3'd7;

    // Marker bit that is always set in the EM result byte.
    localparam logic [7:0] EM_MARK = 8'h80;

    // Classification flags of one cluster.
    typedef struct packed {
        logic em_low;
        logic em_high;
        logic had_low;
        logic had_high;
    } cct_flags_t;

    // Energy and ratio cuts shared by all clusters.
    typedef struct packed {
        logic [RATIO_W-1:0] em_ratio;
        logic [RATIO_W-1:0] had_ratio;
        logic [THR_W-1:0]   em_low;
        logic [THR_W-1:0]   em_high;
        logic [THR_W-1:0]   had_low;
        logic [THR_W-1:0]   had_high;
    } cct_cuts_t;

endpackage

`default_nettype wire

@@ rtl/calorimeter_cluster_trigger_classifier.sv @@
`default_nettype none

// Calorimeter cluster trigger classifier.
// A crossing is one transaction: it is taken at a rising edge where start is
// high and busy is low. busy never rises, so a crossing may be presented on
// every clock. The block registers the links, forms nine 2x2 tower sums and the
// hadronic sum, registers the ratio products in each cluster unit, then
// compares and packs the result bytes into the output register.
// Each result shows on the output ports for one cycle with done high, after
// the input, tower sum, ratio product and output registers; one result per crossing, in
// order, at one crossing per cycle. The receiver cannot hold results off.
// Cuts are written through cfg_we, cfg_index and cfg_data, one register per
// edge; they must only change while no crossing is in flight.
// Reset clears all cuts to zero and empties the pipeline; no result is
// strobed until a crossing has been taken after reset.
module calorimeter_cluster_trigger_classifier
    import cct_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [LINK_W-1:0]    ecal_left_link,
    input  wire logic [LINK_W-1:0]    ecal_right_link,
    input  wire logic [LINK_W-1:0]    hcal_link,
    input  wire logic [7:0]           pres_bits_row,
    input  wire logic [7:0]           pres_extra_a,
    input  wire logic [7:0]           pres_extra_b,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output logic                      done,
    output logic [7:0]                em_byte,
    output logic [5:0]                gamma_byte,
    output logic [5:0]                electron_byte,
    output logic [5:0]                hadron_byte,
    output logic [1:0]                jet_byte,
    output logic [7:0]                pres_out0,
    output logic [7:0]                pres_out1,
    output logic [7:0]                pres_out7
);

    // Configuration registers.
    cct_cuts_t          cuts_reg;
    logic [THR_W-1:0]   jet_ecal_reg;
    logic [THR_W-1:0]   jet_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cuts_reg      <= '0;
            jet_ecal_reg  <= '0;
            jet_total_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_EM_RATIO:  cuts_reg.em_ratio  <= cfg_data[RATIO_W-1:0];
                REG_HAD_RATIO: cuts_reg.had_ratio <= cfg_data[RATIO_W-1:0];
                REG_EM_LOW:    cuts_reg.em_low    <= cfg_data[THR_W-1:0];
                REG_EM_HIGH:   cuts_reg.em_high   <= cfg_data[THR_W-1:0];
                REG_HAD_LOW:   cuts_reg.had_low   <= cfg_data[THR_W-1:0];
                REG_HAD_HIGH:  cuts_reg.had_high  <= cfg_data[THR_W-1:0];
                REG_JET_ECAL:  jet_ecal_reg       <= cfg_data[THR_W-1:0];
                REG_JET_TOTAL: jet_total_reg      <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline takes a crossing every cycle.
    assign busy = 1'b0;

    // Valid bits for the pipeline stages.
    logic v0_reg;
    logic v1_reg;
    logic v2_reg;
    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= start && !busy;
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // Stage 0: input register.
    logic [LINK_W-1:0] left_reg;
    logic [LINK_W-1:0] right_reg;
    logic [LINK_W-1:0] hlink_reg;
    logic [7:0]        pres0_reg;
    logic [7:0]        presa0_reg;
    logic [7:0]        presb0_reg;

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            left_reg   <= ecal_left_link;
            right_reg  <= ecal_right_link;
            hlink_reg  <= hcal_link;
            pres0_reg  <= pres_bits_row;
            presa0_reg <= pres_extra_a;
            presb0_reg <= pres_extra_b;
        end
    end

    // Stage 1: tower sums.
    logic [ESUM_W-1:0] esum_next [NUM_CLUSTERS];
    logic [ESUM_W-1:0] hsum_next;
    logic [ETOT_W-1:0] etot_next;
    logic [JSUM_W-1:0] jsum_next;

    always_comb
    begin
        logic [BYTE_W-1:0] tw [GRID_DIM][GRID_DIM];
        for (int r = 0; r < GRID_DIM; r++)
        begin
            for (int c = 0; c < GRID_DIM; c++)
            begin
                if (c < 2)
                    tw[r][c] = left_reg[(2*r+c)*BYTE_W +: BYTE_W];
                else
                    tw[r][c] = right_reg[(2*r+c-2)*BYTE_W +: BYTE_W];
            end
        end
        for (int r = 0; r < CLUSTER_DIM; r++)
        begin
            for (int c = 0; c < CLUSTER_DIM; c++)
            begin
                esum_next[r*CLUSTER_DIM+c] = ESUM_W'(tw[r][c]) + ESUM_W'(tw[r][c+1])
                                           + ESUM_W'(tw[r+1][c]) + ESUM_W'(tw[r+1][c+1]);
            end
        end
        hsum_next = ESUM_W'(hlink_reg[7:0]) + ESUM_W'(hlink_reg[23:16])
                  + ESUM_W'(hlink_reg[39:32]) + ESUM_W'(hlink_reg[55:48]);
        etot_next = ETOT_W'(esum_next[0]) + ETOT_W'(esum_next[2])
                  + ETOT_W'(esum_next[6]) + ETOT_W'(esum_next[8]);
        jsum_next = JSUM_W'(etot_next) + JSUM_W'(hsum_next);
    end

    logic [ESUM_W-1:0] esum_reg [NUM_CLUSTERS];
    logic [ESUM_W-1:0] hsum_reg;
    logic [ETOT_W-1:0] etot_reg;
    logic [JSUM_W-1:0] jsum_reg;
    logic [7:0]        pres1_reg;
    logic [7:0]        presa1_reg;
    logic [7:0]        presb1_reg;

    always_ff @(posedge clk)
    begin
        esum_reg   <= esum_next;
        hsum_reg   <= hsum_next;
        etot_reg   <= etot_next;
        jsum_reg   <= jsum_next;
        pres1_reg  <= pres0_reg;
        presa1_reg <= presa0_reg;
        presb1_reg <= presb0_reg;
    end

    // Stage 2: ratio products in each cluster unit, jet compares here.
    cct_flags_t flags [NUM_CLUSTERS];

    for (genvar k = 0; k < NUM_CLUSTERS; k++)
    begin : g_cluster
        cct_cluster u_cluster (
            .clk   (clk),
            .esum  (esum_reg[k]),
            .hsum  (hsum_reg),
            .cuts  (cuts_reg),
            .flags (flags[k])
        );
    end

    logic [1:0] jet2_reg;
    logic [7:0] pres2_reg;
    logic [7:0] presa2_reg;
    logic [7:0] presb2_reg;

    always_ff @(posedge clk)
    begin
        jet2_reg[0] <= THR_W'(etot_reg) > jet_ecal_reg;
        jet2_reg[1] <= jsum_reg > jet_total_reg;
        pres2_reg   <= pres1_reg;
        presa2_reg  <= presa1_reg;
        presb2_reg  <= presb1_reg;
    end

    // Stage 3: merge cluster flags by row and pack the result bytes.
    logic [7:0] em_next;
    logic [5:0] gamma_next;
    logic [5:0] electron_next;
    logic [5:0] hadron_next;

    always_comb
    begin
        logic [CLUSTER_DIM-1:0] em1;
        logic [CLUSTER_DIM-1:0] em2;
        logic [CLUSTER_DIM-1:0] had1;
        logic [CLUSTER_DIM-1:0] had2;
        logic [CLUSTER_DIM-1:0] charged;
        em1  = '0;
        em2  = '0;
        had1 = '0;
        had2 = '0;
        for (int r = 0; r < CLUSTER_DIM; r++)
        begin
            for (int c = 0; c < CLUSTER_DIM; c++)
            begin
                em1[r]  = em1[r]  | flags[r*CLUSTER_DIM+c].em_low;
                em2[r]  = em2[r]  | flags[r*CLUSTER_DIM+c].em_high;
                had1[r] = had1[r] | flags[r*CLUSTER_DIM+c].had_low;
                had2[r] = had2[r] | flags[r*CLUSTER_DIM+c].had_high;
            end
        end
        charged       = pres2_reg[CLUSTER_DIM-1:0];
        em_next       = EM_MARK | {2'b00, em2, em1};
        gamma_next    = {em2 & ~charged, em1 & ~charged};
        electron_next = {em2 & charged, em1 & charged};
        hadron_next   = {had2, had1};
    end

    logic [7:0] em_reg;
    logic [5:0] gamma_reg;
    logic [5:0] electron_reg;
    logic [5:0] hadron_reg;
    logic [1:0] jet_reg;
    logic [7:0] pres_out0_reg;
    logic [7:0] pres_out1_reg;
    logic [7:0] pres_out7_reg;

    always_ff @(posedge clk)
    begin
        em_reg        <= em_next;
        gamma_reg     <= gamma_next;
        electron_reg  <= electron_next;
        hadron_reg    <= hadron_next;
        jet_reg       <= jet2_reg;
        pres_out0_reg <= pres2_reg;
        pres_out1_reg <= presa2_reg;
        pres_out7_reg <= presb2_reg;
    end

    assign done          = done_reg;
    assign em_byte       = em_reg;
    assign gamma_byte    = gamma_reg;
    assign electron_byte = electron_reg;
    assign hadron_byte   = hadron_reg;
    assign jet_byte      = jet_reg;
    assign pres_out0     = pres_out0_reg;
    assign pres_out1     = pres_out1_reg;
    assign pres_out7     = pres_out7_reg;

endmodule

`default_nettype wire

@@ rtl/cct_cluster.sv @@
`default_nettype none

module cct_cluster
    import cct_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [ESUM_W-1:0] esum,
    input  wire logic [ESUM_W-1:0] hsum,
    input  wire cct_cuts_t         cuts,
    output cct_flags_t             flags
);

    logic [PROD_W-1:0] em_prod_reg;
    logic [PROD_W-1:0] had_prod_reg;
    logic [PROD_W-1:0] h128_reg;
    logic [TOT_W-1:0]  tot_reg;

    logic [PROD_W-1:0] em_prod_next;
    logic [PROD_W-1:0] had_prod_next;
    logic [PROD_W-1:0] h128_next;
    logic [TOT_W-1:0]  tot_next;

    // Ratio products and cluster total; registered before the compares.
    always_comb
    begin
        em_prod_next  = PROD_W'(esum) * PROD_W'(cuts.em_ratio);
        had_prod_next = PROD_W'(esum) * PROD_W'(cuts.had_ratio);
        h128_next     = {1'b0, hsum, 7'd0};
        tot_next      = TOT_W'(esum) + TOT_W'(hsum);
    end

    always_ff @(posedge clk)
    begin
        em_prod_reg  <= em_prod_next;
        had_prod_reg <= had_prod_next;
        h128_reg     <= h128_next;
        tot_reg      <= tot_next;
    end

    // Class tests with strict compares; equal products fall in neither class.
    always_comb
    begin
        logic is_em;
        logic is_had;
        is_em          = h128_reg < em_prod_reg;
        is_had         = h128_reg > had_prod_reg;
        flags.em_low   = is_em  && (THR_W'(tot_reg) > cuts.em_low);
        flags.em_high  = is_em  && (THR_W'(tot_reg) > cuts.em_high);
        flags.had_low  = is_had && (THR_W'(tot_reg) > cuts.had_low);
        flags.had_high = is_had && (THR_W'(tot_reg) > cuts.had_high);
    end

endmodule

`default_nettype wire

@@ tb/cct_tb_pkg.sv @@
`default_nettype none

package cct_tb_pkg;

    import cct_pkg::*;

    // One beam crossing as presented on the input ports.
    typedef struct {
        logic [LINK_W-1:0] left;
        logic [LINK_W-1:0] right;
        logic [LINK_W-1:0] hcal;
        logic [7:0]        pres_row;
        logic [7:0]        extra_a;
        logic [7:0]        extra_b;
    } crossing_t;

    // One packed trigger word as it leaves the block.
    typedef struct {
        logic [7:0] em;
        logic [5:0] gamma;
        logic [5:0] electron;
        logic [5:0] hadron;
        logic [1:0] jet;
        logic [7:0] pres0;
        logic [7:0] pres1;
        logic [7:0] pres7;
    } trigger_word_t;

    // Keeps a copy of the cuts, predicts the trigger word of every accepted
    // crossing and compares it with what the block strobes out.
    class trigger_scoreboard;

        logic [RATIO_W-1:0] em_ratio;
        logic [RATIO_W-1:0] had_ratio;
        logic [THR_W-1:0]   em_low;
        logic [THR_W-1:0]   em_high;
        logic [THR_W-1:0]   had_low;
        logic [THR_W-1:0]   had_high;
        logic [THR_W-1:0]   jet_ecal;
        logic [THR_W-1:0]   jet_total;

        trigger_word_t pending_words[$];
        int unsigned   mismatches;

        function new();
            em_ratio   = '0;
            had_ratio  = '0;
            em_low     = '0;
            em_high    = '0;
            had_low    = '0;
            had_high   = '0;
            jet_ecal   = '0;
            jet_total  = '0;
            mismatches = 0;
        endfunction

        // Mirror a register write; the ratio cuts keep only their low byte.
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_EM_RATIO:  em_ratio  = data[RATIO_W-1:0];
                REG_HAD_RATIO: had_ratio = data[RATIO_W-1:0];
                REG_EM_LOW:    em_low    = data[THR_W-1:0];
                REG_EM_HIGH:   em_high   = data[THR_W-1:0];
                REG_HAD_LOW:   had_low   = data[THR_W-1:0];
                REG_HAD_HIGH:  had_high  = data[THR_W-1:0];
                REG_JET_ECAL:  jet_ecal  = data[THR_W-1:0];
                REG_JET_TOTAL: jet_total = data[THR_W-1:0];
                default: ;
            endcase
        endfunction

        // Tower byte at grid row r, column c.
        function int unsigned tower_energy(crossing_t x, int r, int c);
            if (c < 2)
                return x.left[(2 * r + c) * 8 +: 8];
            return x.right[(2 * r + c - 2) * 8 +: 8];
        endfunction

        function trigger_word_t classify(crossing_t x);
            trigger_word_t w;
            int unsigned   hsum;
            int unsigned   h128;
            int unsigned   e;
            int unsigned   tot;
            int unsigned   etot;
            int unsigned   cl[3][3];
            logic [2:0]    em1, em2, g1, g2, e1, e2, had1, had2;
            logic          charged;
            hsum = 0;
            for (int k = 0; k < 4; k++)
                hsum += x.hcal[16 * k +: 8];
            h128 = hsum * 128;
            em1 = '0; em2 = '0; g1 = '0; g2 = '0;
            e1 = '0; e2 = '0; had1 = '0; had2 = '0;
            for (int r = 0; r < 3; r++) begin
                charged = x.pres_row[r];
                for (int c = 0; c < 3; c++) begin
                    e = tower_energy(x, r, c) + tower_energy(x, r, c + 1) +
                        tower_energy(x, r + 1, c) + tower_energy(x, r + 1, c + 1);
                    tot = e + hsum;
                    cl[r][c] = e;
                    // EM class feeds the photon or electron bit of its row.
                    if (h128 < e * em_ratio) begin
                        if (tot > em_low) begin
                            em1[r] = 1'b1;
                            if (charged) e1[r] = 1'b1; else g1[r] = 1'b1;
                        end
                        if (tot > em_high) begin
                            em2[r] = 1'b1;
                            if (charged) e2[r] = 1'b1; else g2[r] = 1'b1;
                        end
                    end
                    if (h128 > e * had_ratio) begin
                        if (tot > had_low)  had1[r] = 1'b1;
                        if (tot > had_high) had2[r] = 1'b1;
                    end
                end
            end
            // Jet bits use the four corner clusters only.
            etot = cl[0][0] + cl[0][2] + cl[2][0] + cl[2][2];
            w.em       = EM_MARK | {2'b00, em2, em1};
            w.gamma    = {g2, g1};
            w.electron = {e2, e1};
            w.hadron   = {had2, had1};
            w.jet      = {(etot + hsum) > jet_total, etot > jet_ecal};
            w.pres0    = x.pres_row;
            w.pres1    = x.extra_a;
            w.pres7    = x.extra_b;
            return w;
        endfunction

        function void note_crossing(crossing_t x);
            pending_words.push_back(classify(x));
        endfunction

        function void check_word(trigger_word_t got);
            trigger_word_t want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: em=%h gamma=%h electron=%h hadron=%h jet=%h",
                             got.em, got.gamma, got.electron, got.hadron, got.jet);
                return;
            end
            want = pending_words.pop_front();
            if (got.em !== want.em || got.gamma !== want.gamma ||
                got.electron !== want.electron || got.hadron !== want.hadron ||
                got.jet !== want.jet || got.pres0 !== want.pres0 ||
                got.pres1 !== want.pres1 || got.pres7 !== want.pres7) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result differs: expected em=%h gamma=%h electron=%h hadron=%h %s",
                             want.em, want.gamma, want.electron, want.hadron,
                             $sformatf("jet=%h p0=%h p1=%h p7=%h",
                                       want.jet, want.pres0, want.pres1, want.pres7));
                    $display("                actual   em=%h gamma=%h electron=%h hadron=%h %s",
                             got.em, got.gamma, got.electron, got.hadron,
                             $sformatf("jet=%h p0=%h p1=%h p7=%h",
                                       got.jet, got.pres0, got.pres1, got.pres7));
                end
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        // Any word still waiting at the end counts as a failure.
        function void close_out();
            if (pending_words.size() != 0) begin
                $display("%0d expected results never arrived", pending_words.size());
                mismatches += pending_words.size();
            end
        endfunction

    endclass

endpackage

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;

    import cct_pkg::*;
    import cct_tb_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [LINK_W-1:0]    ecal_left_link = '0;
    logic [LINK_W-1:0]    ecal_right_link = '0;
    logic [LINK_W-1:0]    hcal_link = '0;
    logic [7:0]           pres_bits_row = '0;
    logic [7:0]           pres_extra_a = '0;
    logic [7:0]           pres_extra_b = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 done;
    logic [7:0]           em_byte;
    logic [5:0]           gamma_byte;
    logic [5:0]           electron_byte;
    logic [5:0]           hadron_byte;
    logic [1:0]           jet_byte;
    logic [7:0]           pres_out0;
    logic [7:0]           pres_out1;
    logic [7:0]           pres_out7;

    trigger_scoreboard sb;

    always #10 clk = ~clk;

    calorimeter_cluster_trigger_classifier dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .ecal_left_link  (ecal_left_link),
        .ecal_right_link (ecal_right_link),
        .hcal_link       (hcal_link),
        .pres_bits_row   (pres_bits_row),
        .pres_extra_a    (pres_extra_a),
        .pres_extra_b    (pres_extra_b),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .em_byte         (em_byte),
        .gamma_byte      (gamma_byte),
        .electron_byte   (electron_byte),
        .hadron_byte     (hadron_byte),
        .jet_byte        (jet_byte),
        .pres_out0       (pres_out0),
        .pres_out1       (pres_out1),
        .pres_out7       (pres_out7)
    );

    // Sample both sides at the rising edge: results first, then the new crossing.
    always @(posedge clk) begin
        crossing_t     seen;
        trigger_word_t got;
        if (rst_n && sb != null) begin
            if (done !== 1'b0) begin
                got.em       = em_byte;
                got.gamma    = gamma_byte;
                got.electron = electron_byte;
                got.hadron   = hadron_byte;
                got.jet      = jet_byte;
                got.pres0    = pres_out0;
                got.pres1    = pres_out1;
                got.pres7    = pres_out7;
                sb.check_word(got);
            end
            if (start && busy === 1'b0) begin
                seen.left     = ecal_left_link;
                seen.right    = ecal_right_link;
                seen.hcal     = hcal_link;
                seen.pres_row = pres_bits_row;
                seen.extra_a  = pres_extra_a;
                seen.extra_b  = pres_extra_b;
                sb.note_crossing(seen);
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        repeat (200000) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    function automatic crossing_t make_crossing(logic [63:0] left, logic [63:0] right,
                                                logic [63:0] hcal, logic [7:0] pres,
                                                logic [7:0] extra_a, logic [7:0] extra_b);
        crossing_t x;
        x.left     = left;
        x.right    = right;
        x.hcal     = hcal;
        x.pres_row = pres;
        x.extra_a  = extra_a;
        x.extra_b  = extra_b;
        return x;
    endfunction

    function automatic logic [63:0] random_link();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly uniform links, plus low-energy, one-sided and near-balanced crossings.
    function automatic crossing_t random_crossing();
        crossing_t   x;
        int unsigned mode;
        int unsigned v;
        int unsigned u;
        mode = $urandom_range(0, 9);
        x = make_crossing(random_link(), random_link(), random_link(),
                          8'($urandom()), 8'($urandom()), 8'($urandom()));
        if (mode == 6 || mode == 7) begin
            for (int k = 0; k < 8; k++) begin
                x.left[8 * k +: 8]  = 8'($urandom_range(0, 31));
                x.right[8 * k +: 8] = 8'($urandom_range(0, 31));
                x.hcal[8 * k +: 8]  = 8'($urandom_range(0, 31));
            end
        end else if (mode == 8) begin
            if ($urandom_range(0, 1) == 0) begin
                x.left  = '0;
                x.right = '0;
            end else begin
                x.hcal = '0;
            end
        end else if (mode == 9) begin
            // Flat towers against a flat hadronic link, close to the unit ratio.
            v = $urandom_range(1, 254);
            u = v + $urandom_range(0, 2) - 1;
            for (int k = 0; k < 8; k++) begin
                x.left[8 * k +: 8]  = 8'(v);
                x.right[8 * k +: 8] = 8'(v);
            end
            for (int k = 0; k < 4; k++)
                x.hcal[16 * k +: 8] = 8'(u);
        end
        return x;
    endfunction

    function automatic int unsigned random_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Present one crossing and hold it until the block takes it.
    task automatic drive_crossing(input crossing_t x);
        @(negedge clk);
        start           = 1'b1;
        ecal_left_link  = x.left;
        ecal_right_link = x.right;
        hcal_link       = x.hcal;
        pres_bits_row   = x.pres_row;
        pres_extra_a    = x.extra_a;
        pres_extra_b    = x.extra_b;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Leave start low, with junk on the left ECAL link, HCAL link and presence row ports.
    task automatic idle_for(input int unsigned n);
        if (n > 0) begin
            @(negedge clk);
            start           = 1'b0;
            ecal_left_link  = random_link();
            hcal_link       = random_link();
            pres_bits_row   = 8'($urandom());
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic settle();
        int unsigned guard;
        guard = 0;
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0 && guard < 2000) begin
            @(posedge clk);
            guard++;
        end
        repeat (5) @(posedge clk);
    endtask

    task automatic write_cut(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.set_reg(idx, data);
    endtask

    task automatic program_cuts(input logic [12:0] em_r, input logic [12:0] had_r,
                                input logic [12:0] em_lo, input logic [12:0] em_hi,
                                input logic [12:0] had_lo, input logic [12:0] had_hi,
                                input logic [12:0] jet_e, input logic [12:0] jet_t);
        write_cut(REG_EM_RATIO, em_r);
        write_cut(REG_HAD_RATIO, had_r);
        write_cut(REG_EM_LOW, em_lo);
        write_cut(REG_EM_HIGH, em_hi);
        write_cut(REG_HAD_LOW, had_lo);
        write_cut(REG_HAD_HIGH, had_hi);
        write_cut(REG_JET_ECAL, jet_e);
        write_cut(REG_JET_TOTAL, jet_t);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Pick a cut: sometimes zero, sometimes all ones, otherwise up to the given top.
    function automatic logic [12:0] random_cut(input int unsigned top);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 13'h0000;
        if (r == 1)
            return 13'h1FFF;
        return 13'($urandom_range(0, top));
    endfunction

    task automatic random_cuts();
        program_cuts(random_cut(8191), random_cut(8191),
                     random_cut(2100), random_cut(2100),
                     random_cut(2100), random_cut(2100),
                     random_cut(5200), random_cut(5200));
    endtask

    initial begin
        int unsigned left_in_burst;
        logic        burst;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Cuts at reset: a zero EM ratio cut lets no cluster be EM.
        drive_crossing(make_crossing('0, '0, '0, 8'h00, 8'h00, 8'h00));
        drive_crossing(make_crossing('1, '1, '1, 8'hFF, 8'h00, 8'hFF));
        drive_crossing(make_crossing('0, '0, '1, 8'h55, 8'hFF, 8'h00));
        drive_crossing(random_crossing());
        settle();

        // Unit ratio cuts: equal products fall in neither class.
        program_cuts(13'd128, 13'd128, 13'd100, 13'd1000, 13'd100, 13'd1000,
                     13'd500, 13'd1500);
        drive_crossing(make_crossing({8{8'h10}}, {8{8'h10}}, 64'hFF10FF10FF10FF10,
                                     8'h07, 8'hA5, 8'h5A));
        drive_crossing(make_crossing({8{8'h11}}, {8{8'h11}}, 64'hFF10FF10FF10FF10,
                                     8'h00, 8'h5A, 8'hA5));
        drive_crossing(make_crossing({8{8'h0F}}, {8{8'h0F}}, 64'h0010001000100010,
                                     8'hFF, 8'h01, 8'h80));
        drive_crossing(make_crossing('1, '1, '0, 8'h05, 8'h80, 8'h01));
        drive_crossing(make_crossing('1, '1, '0, 8'hFA, 8'h7F, 8'hFE));
        drive_crossing(make_crossing(64'h000000000000FFFF, 64'h000000000000FFFF, '0,
                                     8'h01, 8'h00, 8'h00));
        drive_crossing(make_crossing('0, 64'hFF00000000000000, 64'h0000000000000001,
                                     8'h04, 8'h00, 8'h00));
        drive_crossing(make_crossing('1, '0, 64'hFF00FF00FF00FF00, 8'h02, 8'hC3, 8'h3C));
        settle();

        // Every cut at its widest value; the ratio cuts keep only 255.
        program_cuts(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF,
                     13'h1FFF, 13'h1FFF);
        drive_crossing(make_crossing('1, '1, '1, 8'hFF, 8'hFF, 8'hFF));
        drive_crossing(make_crossing('0, '0, '0, 8'h00, 8'h00, 8'h00));
        drive_crossing(make_crossing('1, '1, '0, 8'h00, 8'h00, 8'h00));
        settle();

        // Zero energy cuts with opposite ratio extremes.
        program_cuts(13'h1EFF, 13'h1F00, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
        drive_crossing(make_crossing('1, '1, '0, 8'h03, 8'h11, 8'h22));
        drive_crossing(make_crossing('1, '1, '1, 8'h06, 8'h33, 8'h44));
        drive_crossing(make_crossing('0, '0, '0, 8'h00, 8'h00, 8'h00));
        drive_crossing(random_crossing());
        drive_crossing(random_crossing());
        settle();

        // Random phases, each under its own cuts, with bursts and gaps.
        for (int phase = 0; phase < 8; phase++) begin
            random_cuts();
            left_in_burst = 0;
            burst = 1'b0;
            for (int n = 0; n < 75; n++) begin
                if (left_in_burst == 0) begin
                    left_in_burst = $urandom_range(10, 25);
                    burst = ($urandom_range(0, 2) == 0);
                end
                left_in_burst--;
                drive_crossing(random_crossing());
                if (phase == 3 && n == 40)
                    settle();
                else if (!burst)
                    idle_for(random_gap());
            end
            settle();
        end

        sb.close_out();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
